// ===== rtl/hst_pkg.sv =====
package hst_pkg;

    localparam int ANGLE_BITS = 16;
    localparam int ACC_W      = 32;
    localparam int RATE_W     = 24;
    localparam int TIME_W     = 20;
    localparam int MUL_SPLIT  = TIME_W / 2;
    localparam int PROD_W     = RATE_W + TIME_W;
    localparam int TABLE_LEN  = 24;
    localparam int TBL_IDX_W  = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [RATE_W-1:0] RATE_RESET = 24'd45813;
    localparam logic [ANGLE_BITS-1:0] HALF_TURN = 16'h8000;
    localparam logic [ACC_W-1:0] Z_HALF_TURN = 32'h8000_0000;
    localparam logic [ACC_W-1:0] Z_ROUND = 32'(1) << (ACC_W - ANGLE_BITS - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PIVOT_X  = 2'd0,
        CFG_PIVOT_Y  = 2'd1,
        CFG_MAX_RATE = 2'd2
    } t_cfg_idx;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_ROT  = 6'b000010,
        S_MUL0 = 6'b000100,
        S_MUL1 = 6'b001000,
        S_DIFF = 6'b010000,
        S_UPD  = 6'b100000
    } t_state;

    // atan(2^-i) in 2^32-per-turn units
    function automatic logic [ACC_W-1:0] atan_turns(input logic [TBL_IDX_W-1:0] idx);
        logic [ACC_W-1:0] v;
        case (idx)
            5'd0:    v = 32'h2000_0000;
            5'd1:    v = 32'h12E4_051E;
            5'd2:    v = 32'h09FB_385B;
            5'd3:    v = 32'h0511_11D4;
            5'd4:    v = 32'h028B_0D43;
            5'd5:    v = 32'h0145_D7E1;
            5'd6:    v = 32'h00A2_F61E;
            5'd7:    v = 32'h0051_7C55;
            5'd8:    v = 32'h0028_BE53;
            5'd9:    v = 32'h0014_5F2F;
            5'd10:   v = 32'h000A_2F98;
            5'd11:   v = 32'h0005_17CC;
            5'd12:   v = 32'h0002_8BE6;
            5'd13:   v = 32'h0001_45F3;
            5'd14:   v = 32'h0000_A2F9;
            5'd15:   v = 32'h0000_517C;
            5'd16:   v = 32'h0000_28BE;
            5'd17:   v = 32'h0000_145F;
            5'd18:   v = 32'h0000_0A2F;
            5'd19:   v = 32'h0000_0517;
            5'd20:   v = 32'h0000_028B;
            5'd21:   v = 32'h0000_0145;
            5'd22:   v = 32'h0000_00A2;
            5'd23:   v = 32'h0000_0051;
            default: v = 32'h0000_0051;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/heading_slew_tracker.sv =====
// heading_slew_tracker: turns a stored heading toward a target point at a
// bounded rate.
// input channel: i_in_valid / o_in_stall carries target_x, target_y and
// elapsed_time; a request is taken when valid is high and stall is low.
// output channel: o_out_valid / i_out_stall carries the new heading and the
// raw direction to the target, one result per request.
// config channel: i_cfg_valid / o_cfg_ready writes pivot_x (0), pivot_y (1)
// or max_rate (2); ready is always high, write only while no request is in flight.
// steps: the accepting edge loads the request, then CORDIC_STEPS rotation
// steps run on the shared add/shift unit, the shared 24x10 multiplier forms
// the turn limit in S_MUL0 and S_MUL1, and S_DIFF and S_UPD do wrap, clamp
// and update, S_UPD loading the output register once it is free.
// one request at a time: o_in_stall stays high after acceptance until the
// result is loaded into the output register; the next request can then be taken.
// a stalled receiver holds the output register; the next request may be
// accepted meanwhile and then waits in its final cycle for the slot.
// reset (synchronous, active low) sets the heading to 0, the registers to
// pivot 400/300 and rate 45813, and drops o_out_valid.
module heading_slew_tracker #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS   = 12
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // request channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [COORD_BITS-1:0]               i_target_x,
    input  logic [COORD_BITS-1:0]               i_target_y,
    input  logic [hst_pkg::TIME_W-1:0]          i_elapsed_time,
    // result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [hst_pkg::ANGLE_BITS-1:0]      o_heading,
    output logic [hst_pkg::ANGLE_BITS-1:0]      o_target_heading,
    // config channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [hst_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [hst_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import hst_pkg::*;

    // datapath width: sign, coordinate, 16 fraction bits, 2 bits of CORDIC growth
    localparam int W      = COORD_BITS + 19;
    localparam int STEP_W = $clog2(CORDIC_STEPS);
    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

    // configuration registers
    logic [COORD_BITS-1:0] r_pivot_x;
    logic [COORD_BITS-1:0] r_pivot_y;
    logic [RATE_W-1:0]     r_max_rate;

    t_state r_state, n_state;

    logic signed [W-1:0]    r_x, r_y;
    logic [ACC_W-1:0]       r_z;
    logic                   r_zero;
    logic [STEP_W-1:0]      r_step;
    logic [TIME_W-1:0]      r_time;
    logic [PROD_W-1:0]      r_prod;
    logic [ANGLE_BITS-1:0]  r_target;
    logic signed [ANGLE_BITS:0] r_diff;
    logic [ANGLE_BITS-1:0]  r_lim;
    logic [ANGLE_BITS-1:0]  r_heading;

    logic                   r_out_valid;
    logic [ANGLE_BITS-1:0]  r_out_heading;
    logic [ANGLE_BITS-1:0]  r_out_target;

    logic in_acc, out_free;

    // request load: offsets from the pivot, left half plane folded over
    logic signed [COORD_BITS:0] dx, dy;
    logic signed [W-1:0]        x0, y0;

    // shared rotation unit
    logic [TBL_IDX_W-1:0]   k;
    logic signed [W-1:0]    xs, ys;
    logic [ACC_W-1:0]       atan_k;

    // shared multiplier for the turn limit
    logic [MUL_SPLIT-1:0]        mul_b;
    logic [RATE_W+MUL_SPLIT-1:0] mul_p;

    logic [ACC_W-1:0]            z_rnd;
    logic [ANGLE_BITS-1:0]       target_c, raw;
    logic [TIME_W-1:0]           lim_raw;
    logic signed [ANGLE_BITS:0]  lim_s, clamped;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_out_valid      = r_out_valid;
    assign o_heading        = r_out_heading;
    assign o_target_heading = r_out_target;

    always_comb begin
        dx = $signed({1'b0, i_target_x}) - $signed({1'b0, r_pivot_x});
        dy = $signed({1'b0, i_target_y}) - $signed({1'b0, r_pivot_y});
        x0 = {{(W - COORD_BITS - 17){dx[COORD_BITS]}}, dx, 16'b0};
        y0 = {{(W - COORD_BITS - 17){dy[COORD_BITS]}}, dy, 16'b0};
    end

    always_comb begin
        if (int'(r_step) >= TABLE_LEN) begin
            k = TBL_IDX_W'(TABLE_LEN - 1);
        end else begin
            k = TBL_IDX_W'(r_step);
        end
        xs     = r_x >>> k;
        ys     = r_y >>> k;
        atan_k = atan_turns(k);
    end

    // low half of elapsed time first, then the high half
    assign mul_b = (r_state == S_MUL0) ? r_time[MUL_SPLIT-1:0]
                                       : r_time[TIME_W-1:MUL_SPLIT];
    assign mul_p = r_max_rate * mul_b;

    always_comb begin
        z_rnd    = r_z + Z_ROUND;
        target_c = r_zero ? '0 : z_rnd[ACC_W-1 -: ANGLE_BITS];
        // shortest difference, half a turn counts as negative
        raw      = target_c - r_heading;
        lim_raw  = r_prod[PROD_W-1:RATE_W];
        lim_s    = $signed({1'b0, r_lim});
        if (r_diff > lim_s) begin
            clamped = lim_s;
        end else if (r_diff < -lim_s) begin
            clamped = -lim_s;
        end else begin
            clamped = r_diff;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (in_acc) n_state = S_ROT;
            S_ROT:   if (r_step == LAST_STEP) n_state = S_MUL0;
            S_MUL0:  n_state = S_MUL1;
            S_MUL1:  n_state = S_DIFF;
            S_DIFF:  n_state = S_UPD;
            S_UPD:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_heading   <= '0;
            r_pivot_x   <= COORD_BITS'(400);
            r_pivot_y   <= COORD_BITS'(300);
            r_max_rate  <= RATE_RESET;
        end else begin
            r_state <= n_state;

            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PIVOT_X:  r_pivot_x  <= i_cfg_data[COORD_BITS-1:0];
                    CFG_PIVOT_Y:  r_pivot_y  <= i_cfg_data[COORD_BITS-1:0];
                    CFG_MAX_RATE: r_max_rate <= i_cfg_data[RATE_W-1:0];
                    default:      ;
                endcase
            end

            // heading and result register move together
            if (r_state == S_UPD && out_free) begin
                r_heading     <= r_heading + clamped[ANGLE_BITS-1:0];
                r_out_heading <= r_heading + clamped[ANGLE_BITS-1:0];
                r_out_target  <= r_target;
                r_out_valid   <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath, no reset
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_step <= '0;
                    r_time <= i_elapsed_time;
                    r_zero <= (dx == '0) && (dy == '0);
                    if (dx[COORD_BITS]) begin
                        r_x <= -x0;
                        r_y <= -y0;
                        r_z <= Z_HALF_TURN;
                    end else begin
                        r_x <= x0;
                        r_y <= y0;
                        r_z <= '0;
                    end
                end
            end
            S_ROT: begin
                r_step <= r_step + 1'b1;
                if (r_y > 0) begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + atan_k;
                end else begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - atan_k;
                end
            end
            S_MUL0: r_prod <= PROD_W'(mul_p);
            S_MUL1: r_prod <= r_prod + (PROD_W'(mul_p) << MUL_SPLIT);
            S_DIFF: begin
                r_target <= target_c;
                r_diff   <= $signed({raw[ANGLE_BITS-1], raw});
                r_lim    <= (lim_raw > TIME_W'(HALF_TURN)) ? HALF_TURN
                                                           : lim_raw[ANGLE_BITS-1:0];
            end
            default: ;
        endcase
    end

    a_stall_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> o_in_stall)
        else $error("request accepted while a request is in flight");

    a_heading_tracks_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_heading == r_heading))
        else $error("stored heading differs from delivered heading");

    a_step_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROT) |-> (int'(r_step) < CORDIC_STEPS))
        else $error("rotation step past last step");

    a_zero_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && r_zero) |-> (r_target == '0))
        else $error("target at pivot must give heading zero");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPD && !out_free) |=> (r_state == S_UPD))
        else $error("result dropped while output stalled");

endmodule

// ===== tb/hst_checker.sv =====
`timescale 1ns / 1ps

module hst_checker #(
    parameter int CORDIC_STEPS = 16,
    parameter int COORD_BITS   = 12
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [COORD_BITS-1:0]            i_target_x,
    input  logic [COORD_BITS-1:0]            i_target_y,
    input  logic [hst_pkg::TIME_W-1:0]       i_elapsed_time,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [hst_pkg::ANGLE_BITS-1:0]   i_heading,
    input  logic [hst_pkg::ANGLE_BITS-1:0]   i_target_heading,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [hst_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hst_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import hst_pkg::*;

    localparam int LUT_LEN = 24;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] heading;
        logic [ANGLE_BITS-1:0] target_heading;
    } t_bearing;

    // atan(2^-i), 2^32 units per turn
    logic [31:0] atan_lut [LUT_LEN];

    logic [COORD_BITS-1:0] pivot_x;
    logic [COORD_BITS-1:0] pivot_y;
    logic [RATE_W-1:0]     turn_rate;
    logic [ANGLE_BITS-1:0] heading_now;
    t_bearing              bearing_q [$];
    t_bearing              want;

    initial begin
        atan_lut = '{
            32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
            32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
            32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
            32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2F9, 32'h0000_517C,
            32'h0000_28BE, 32'h0000_145F, 32'h0000_0A2F, 32'h0000_0517,
            32'h0000_028B, 32'h0000_0145, 32'h0000_00A2, 32'h0000_0051
        };
        o_fail_count = 0;
        o_pending    = 0;
    end

    // vectoring cordic on the offset from the pivot
    function automatic logic [ANGLE_BITS-1:0] aim_angle(input longint dx, input longint dy);
        longint      x;
        longint      y;
        longint      xs;
        longint      ys;
        logic [31:0] z;
        int          k;
        int          i;
        if (dx == 0 && dy == 0) begin
            return '0;
        end
        x = dx * 65536;
        y = dy * 65536;
        z = '0;
        if (x < 0) begin
            x = -x;
            y = -y;
            z = 32'h8000_0000;
        end
        for (i = 0; i < CORDIC_STEPS; i++) begin
            k  = (i < LUT_LEN) ? i : LUT_LEN - 1;
            xs = x >>> k;
            ys = y >>> k;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + atan_lut[k];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - atan_lut[k];
            end
        end
        z = z + (32'd1 << (32 - ANGLE_BITS - 1));
        return z[31 -: ANGLE_BITS];
    endfunction

    // shortest turn toward the target, bounded by rate times elapsed time
    function automatic t_bearing slew_toward(input logic [COORD_BITS-1:0] tx,
                                             input logic [COORD_BITS-1:0] ty,
                                             input logic [TIME_W-1:0] dt,
                                             input logic [ANGLE_BITS-1:0] cur);
        t_bearing              res;
        logic [ANGLE_BITS-1:0] gap;
        longint                delta;
        longint                reach;
        res.target_heading = aim_angle(longint'(tx) - longint'(pivot_x),
                                       longint'(ty) - longint'(pivot_y));
        gap   = res.target_heading - cur;
        delta = (gap >= HALF_TURN) ? longint'(gap) - (longint'(1) << ANGLE_BITS)
                                   : longint'(gap);
        reach = (longint'(turn_rate) * longint'(dt)) >>> 24;
        if (reach > longint'(HALF_TURN)) reach = longint'(HALF_TURN);
        if (delta > reach) delta = reach;
        if (delta < -reach) delta = -reach;
        res.heading = cur + delta[ANGLE_BITS-1:0];
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pivot_x     <= COORD_BITS'(400);
            pivot_y     <= COORD_BITS'(300);
            turn_rate   <= RATE_RESET;
            heading_now <= '0;
            bearing_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_PIVOT_X:  pivot_x   <= i_cfg_data[COORD_BITS-1:0];
                    CFG_PIVOT_Y:  pivot_y   <= i_cfg_data[COORD_BITS-1:0];
                    CFG_MAX_RATE: turn_rate <= i_cfg_data[RATE_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (bearing_q.size() == 0) begin
                    $error("result with no request outstanding: heading %0h target %0h",
                           i_heading, i_target_heading);
                    o_fail_count = o_fail_count + 1;
                end else begin
                    want = bearing_q.pop_front();
                    if (i_heading !== want.heading) begin
                        $error("heading: expected %0h, got %0h", want.heading, i_heading);
                        o_fail_count = o_fail_count + 1;
                    end
                    if (i_target_heading !== want.target_heading) begin
                        $error("target_heading: expected %0h, got %0h",
                               want.target_heading, i_target_heading);
                        o_fail_count = o_fail_count + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                want = slew_toward(i_target_x, i_target_y, i_elapsed_time, heading_now);
                heading_now <= want.heading;
                bearing_q.push_back(want);
            end
        end
        o_pending = bearing_q.size();
    end

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import hst_pkg::*;

    localparam int CORDIC_STEPS = 16;
    localparam int COORD_BITS   = 12;
    localparam int COORD_MAX    = (1 << COORD_BITS) - 1;
    // index 3 is decoded by nobody, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY
    } t_stall_mode;

    typedef enum logic {
        GAPS_OFF,
        GAPS_ON
    } t_gap_mode;

    logic                   clk;
    logic                   rst_n;
    logic                   in_valid;
    logic                   in_stall;
    logic [COORD_BITS-1:0]  target_x;
    logic [COORD_BITS-1:0]  target_y;
    logic [TIME_W-1:0]      elapsed_time;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [ANGLE_BITS-1:0]  heading;
    logic [ANGLE_BITS-1:0]  target_heading;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    int                     fail_count;
    int                     pending;

    // stimulus bookkeeping
    t_stall_mode            stall_mode = STALL_NONE;
    t_gap_mode              gap_mode   = GAPS_OFF;
    int                     stall_run  = 0;
    logic                   stall_now;
    int                     burst_left = 0;
    int                     sent       = 0;
    int                     settings   = 1;
    logic [COORD_BITS-1:0]  cur_pivot_x = COORD_BITS'(400);
    logic [COORD_BITS-1:0]  cur_pivot_y = COORD_BITS'(300);

    heading_slew_tracker #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .COORD_BITS   (COORD_BITS)
    ) u_top (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_target_x       (target_x),
        .i_target_y       (target_y),
        .i_elapsed_time   (elapsed_time),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_heading        (heading),
        .o_target_heading (target_heading),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    hst_checker #(
        .CORDIC_STEPS (CORDIC_STEPS),
        .COORD_BITS   (COORD_BITS)
    ) u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_target_x       (target_x),
        .i_target_y       (target_y),
        .i_elapsed_time   (elapsed_time),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_heading        (heading),
        .i_target_heading (target_heading),
        .i_cfg_valid      (cfg_valid),
        .i_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // 10 ns clock
    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // receiver back-pressure: alternating runs of stall and flow,
    // run lengths depend on the current mode
    always @(negedge clk) begin
        if (stall_mode == STALL_NONE) begin
            stall_run = 0;
            out_stall <= 1'b0;
        end else if (stall_run == 0) begin
            stall_now = ($urandom_range(0, 99) < (stall_mode == STALL_LIGHT ? 25 : 60));
            if (stall_now)
                stall_run = $urandom_range(1, stall_mode == STALL_LIGHT ? 4 : 30);
            else
                stall_run = $urandom_range(1, 12);
            out_stall <= stall_now;
        end else begin
            stall_run = stall_run - 1;
        end
    end

    // keep a coordinate on the grid
    function automatic logic [COORD_BITS-1:0] coord_clip(input int v);
        if (v < 0) return '0;
        if (v > COORD_MAX) return COORD_MAX[COORD_BITS-1:0];
        return v[COORD_BITS-1:0];
    endfunction

    // register write, only ever issued while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
        // mirror the pivot so random requests can aim near it
        if (idx == CFG_PIVOT_X) cur_pivot_x = data[COORD_BITS-1:0];
        if (idx == CFG_PIVOT_Y) cur_pivot_y = data[COORD_BITS-1:0];
    endtask

    // one request; valid stays up afterwards so bursts run back to back
    task automatic issue(input logic [COORD_BITS-1:0] tx, input logic [COORD_BITS-1:0] ty,
                         input logic [TIME_W-1:0] dt);
        if (gap_mode == GAPS_ON) begin
            if (burst_left == 0) begin
                @(negedge clk);
                in_valid = 1'b0;
                repeat ($urandom_range(0, 14)) @(negedge clk);
                burst_left = $urandom_range(1, 8);
            end
            burst_left = burst_left - 1;
        end
        @(negedge clk);
        in_valid     = 1'b1;
        target_x     = tx;
        target_y     = ty;
        elapsed_time = dt;
        do @(posedge clk); while (in_stall);
        sent = sent + 1;
    endtask

    // drain all results, then give the block time to go fully idle
    task automatic settle();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (CORDIC_STEPS + 15) @(negedge clk);
    endtask

    // random request: mix of pivot hits, axes, near-pivot, diagonals and
    // open-field targets; elapsed time spread so the rate clamp both bites
    // and saturates
    task automatic random_request();
        int                    pick;
        int                    d;
        logic [COORD_BITS-1:0] tx;
        logic [COORD_BITS-1:0] ty;
        logic [TIME_W-1:0]     dt;
        pick = $urandom_range(0, 99);
        tx   = COORD_BITS'($urandom);
        ty   = COORD_BITS'($urandom);
        if (pick < 8) begin
            tx = cur_pivot_x;
            ty = cur_pivot_y;
        end else if (pick < 18) begin
            if ($urandom_range(0, 1)) tx = cur_pivot_x;
            else ty = cur_pivot_y;
        end else if (pick < 35) begin
            tx = coord_clip(int'(cur_pivot_x) + $urandom_range(0, 6) - 3);
            ty = coord_clip(int'(cur_pivot_y) + $urandom_range(0, 6) - 3);
        end else if (pick < 45) begin
            d  = $urandom_range(1, 2047);
            tx = coord_clip(int'(cur_pivot_x) + ($urandom_range(0, 1) ? d : -d));
            ty = coord_clip(int'(cur_pivot_y) + ($urandom_range(0, 1) ? d : -d));
        end
        pick = $urandom_range(0, 99);
        if (pick < 10)      dt = '0;
        else if (pick < 40) dt = TIME_W'($urandom_range(0, 4095));
        else if (pick < 70) dt = TIME_W'($urandom_range(0, 65535));
        else                dt = TIME_W'($urandom);
        issue(tx, ty, dt);
    endtask

    task automatic random_phase(input int count, input t_gap_mode gaps,
                                input t_stall_mode stalls);
        gap_mode   = gaps;
        stall_mode = stalls;
        burst_left = 0;
        repeat (count) random_request();
    endtask

    // hard stop in case the block hangs
    initial begin
        #8_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        rst_n        = 1'b0;
        in_valid     = 1'b0;
        target_x     = '0;
        target_y     = '0;
        elapsed_time = '0;
        cfg_valid    = 1'b0;
        cfg_index    = CFG_PIVOT_X;
        cfg_data     = '0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: pivot 400/300, slow default rate
        issue(12'd400, 12'd300, 20'd0);         // target on the pivot
        issue(12'd0, 12'd300, 20'd0);           // half a turn off, no time to turn
        issue(12'd0, 12'd300, 20'hFFFFF);       // same, longest elapsed time
        issue(12'd4095, 12'd300, 20'hFFFFF);    // due east
        issue(12'd400, 12'd4095, 20'd1);        // due north, tiny step
        issue(12'd400, 12'd0, 20'hFFFFF);       // due south
        issue(12'd0, 12'd0, 20'hFFFFF);         // grid corners
        issue(12'd4095, 12'd4095, 20'hFFFFF);
        issue(12'd0, 12'd4095, 20'h80000);
        issue(12'd4095, 12'd0, 20'h7FFFF);
        settle();

        // centered pivot, fastest rate: the limit saturates at half a turn
        write_reg(CFG_PIVOT_X, 24'd2048);
        write_reg(CFG_PIVOT_Y, 24'd2048);
        write_reg(CFG_MAX_RATE, 24'hFFFFFF);
        settings = settings + 1;
        issue(12'd4095, 12'd2048, 20'hFFFFF);   // swing onto east
        issue(12'd0, 12'd2048, 20'hFFFFF);      // exactly opposite, full half-turn
        issue(12'd4095, 12'd2048, 20'd32768);   // and back, at the saturation edge
        issue(12'd2048, 12'd2048, 20'hFFFFF);   // on the pivot
        issue(12'd2048, 12'd0, 20'd1);          // limit rounds down to zero
        issue(12'd0, 12'd0, 20'hFFFFF);
        issue(12'd4095, 12'd4095, 20'd40000);
        random_phase(350, GAPS_ON, STALL_LIGHT);
        settle();

        // pivot in the origin corner, zero rate: heading must never move
        write_reg(CFG_PIVOT_X, 24'd0);
        write_reg(CFG_PIVOT_Y, 24'd0);
        write_reg(CFG_MAX_RATE, 24'd0);
        write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
        settings = settings + 1;
        random_phase(300, GAPS_ON, STALL_HEAVY);
        settle();

        // pivot in the far corner, mid rate, no idling on either side
        write_reg(CFG_PIVOT_X, 24'd4095);
        write_reg(CFG_PIVOT_Y, 24'd4095);
        write_reg(CFG_MAX_RATE, 24'h001000);
        settings = settings + 1;
        random_phase(300, GAPS_OFF, STALL_NONE);
        settle();

        // random pivot with junk in the unused data bits, default rate
        write_reg(CFG_PIVOT_X, CFG_DATA_W'($urandom));
        write_reg(CFG_PIVOT_Y, CFG_DATA_W'($urandom));
        write_reg(CFG_MAX_RATE, RATE_RESET);
        settings = settings + 1;
        random_phase(500, GAPS_ON, STALL_LIGHT);
        settle();

        // random pivot and rate, heavy back-pressure
        write_reg(CFG_PIVOT_X, CFG_DATA_W'($urandom));
        write_reg(CFG_PIVOT_Y, CFG_DATA_W'($urandom));
        write_reg(CFG_MAX_RATE, CFG_DATA_W'($urandom));
        settings = settings + 1;
        random_phase(475, GAPS_ON, STALL_HEAVY);

        // drain and let the block run out
        settle();
        stall_mode = STALL_NONE;
        repeat (2 * CORDIC_STEPS) @(negedge clk);

        $display("run covered %0d requests over %0d register settings,", sent, settings);
        $display("with sender gaps and receiver stalls of several patterns");
        if (fail_count == 0 && pending == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
rtl/hst_pkg.sv
rtl/heading_slew_tracker.sv
tb/hst_checker.sv
tb/tb.sv
